// ===== hdl/lfme_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfme_pkg
// Shared types and constants of the localization Fisher matrix entry block.
// ----------------------------------------------------------------------------
package lfme_pkg;

	localparam int POS_W    = 24;
	localparam int DIFF_W   = POS_W + 1;
	localparam int PROD_W   = 2 * DIFF_W;
	localparam int ENTRY_W  = 64;
	localparam int CNT_W    = 5;
	localparam int SLOT_W   = 4;
	localparam int IDX_W    = 5;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 64;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} opcode_t;

	typedef enum logic {
		STS_OK    = 1'b0,
		STS_RANGE = 1'b1
	} status_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_FETCH = 5'b00010,
		ST_ISSUE = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

endpackage

`default_nettype wire

// ===== hdl/lfme_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfme_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/localization_fisher_matrix_entry.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// localization_fisher_matrix_entry
// Stores 2D agent positions and returns one entry of the range-only Fisher
// information matrix per read transaction.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tuser opcode; s_tdata slot, x, y, row, col
// m_*      out  m_tvalid/m_tready  m_tuser status; m_tdata entry_value
// cfg_*    in   cfg_we             cfg_wdata agent_count
//
// A write or an out-of-range read goes straight to the done state and the output register.
// A diagonal read forms one product for each agent in use other than its own, in one shared
// multiply-accumulate, bounded by the single position RAM read port.
// An off-diagonal read forms one product. One transaction is in flight at a time.
// A stalled result holds in the output register; the next transaction is
// accepted meanwhile and waits in the done state. No clearing pass after reset.
// ----------------------------------------------------------------------------
module localization_fisher_matrix_entry #(
	parameter int MAX_AGENTS   = 16,
	parameter int ANCHOR_COUNT = 3
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// [3:0] agent_slot, [27:4] pos_x, [51:28] pos_y, [56:52] row, [61:57] col
	input  wire logic [lfme_pkg::IN_TDATA_W-1:0]   s_tdata,
	// [0] opcode
	input  wire logic                              s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// [63:0] entry_value
	output logic      [lfme_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// [0] status
	output logic                                   m_tuser,
	input  wire logic                              cfg_we,
	input  wire logic [lfme_pkg::CNT_W-1:0]        cfg_wdata
);

	import lfme_pkg::*;

	localparam int AW  = $clog2(MAX_AGENTS);
	localparam int CW  = $clog2(MAX_AGENTS + 1);
	localparam int NW  = (CW > CNT_W) ? CW : CNT_W;
	localparam int RAM_W = 2 * POS_W;

	state_t state_q, state_d;

	logic [CNT_W-1:0]   agent_count_q;
	logic [NW-1:0]      n_cnt, cnt_ext, vars_cnt;
	logic [NW:0]        idx_lim, a_full, b_full;
	logic [NW-1:0]      n_last_full;
	logic [AW-1:0]      n_last;

	opcode_t            in_op;
	logic [SLOT_W-1:0]  in_slot;
	logic [POS_W-1:0]   in_x, in_y;
	logic [IDX_W-1:0]   in_row, in_col;
	logic               s_accept;
	logic               slot_bad, idx_bad;

	logic [AW-1:0]      a_q, b_q, k_q;
	logic               ax_q, bx_q, diag_q;
	logic [ENTRY_W-1:0] acc_q;
	status_t            status_q;

	logic               ram_we;
	logic [AW-1:0]      ram_raddr;
	logic [RAM_W-1:0]   ram_rdata;
	logic [RAM_W-1:0]   pa_q;

	logic               issue_vld;
	logic               load_a_s1, issue_s1;
	logic               vld_s2, vld_s3;
	logic signed [DIFF_W-1:0] d0_s2, d1_s2;
	logic signed [PROD_W-1:0] prod_s3;
	logic signed [POS_W-1:0]  pa_c0, pa_c1, pk_c0, pk_c1;
	logic               out_load;

	assign in_op    = opcode_t'(s_tuser);
	assign in_slot  = s_tdata[3:0];
	assign in_x     = s_tdata[27:4];
	assign in_y     = s_tdata[51:28];
	assign in_row   = s_tdata[56:52];
	assign in_col   = s_tdata[61:57];

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;

	assign cnt_ext     = NW'(agent_count_q);
	assign n_cnt       = (cnt_ext > NW'(MAX_AGENTS)) ? NW'(MAX_AGENTS) : cnt_ext;
	assign vars_cnt    = (n_cnt > NW'(ANCHOR_COUNT)) ? (n_cnt - NW'(ANCHOR_COUNT)) : '0;
	assign idx_lim     = {vars_cnt, 1'b0};
	assign idx_bad     = ((NW+1)'(in_row) >= idx_lim) || ((NW+1)'(in_col) >= idx_lim);
	assign slot_bad    = (NW'(in_slot) >= NW'(MAX_AGENTS));
	assign a_full      = (NW+1)'(in_row[IDX_W-1:1]) + (NW+1)'(ANCHOR_COUNT);
	assign b_full      = (NW+1)'(in_col[IDX_W-1:1]) + (NW+1)'(ANCHOR_COUNT);
	assign n_last_full = n_cnt - NW'(1);
	assign n_last      = n_last_full[AW-1:0];

	assign ram_we    = s_accept && (in_op == OP_WRITE) && !slot_bad;
	assign ram_raddr = (state_q == ST_FETCH) ? a_q : k_q;
	assign issue_vld = (state_q == ST_ISSUE) && (!diag_q || (k_q != a_q));
	assign out_load  = (state_q == ST_DONE) && (!m_tvalid || m_tready);

	lfme_ram #(
		.WIDTH (RAM_W),
		.DEPTH (MAX_AGENTS)
	) u_pos_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(in_slot)),
		.wdata ({in_y, in_x}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		pa_c0 = ax_q ? pa_q[RAM_W-1:POS_W] : pa_q[POS_W-1:0];
		pa_c1 = bx_q ? pa_q[RAM_W-1:POS_W] : pa_q[POS_W-1:0];
		pk_c0 = ax_q ? ram_rdata[RAM_W-1:POS_W] : ram_rdata[POS_W-1:0];
		pk_c1 = bx_q ? ram_rdata[RAM_W-1:POS_W] : ram_rdata[POS_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					if (in_op == OP_READ && !idx_bad) begin
						state_d = ST_FETCH;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_FETCH: begin
				state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				if (!diag_q || k_q == n_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!issue_s1 && !vld_s2 && !vld_s3) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			agent_count_q <= CNT_W'(4);
			load_a_s1     <= 1'b0;
			issue_s1      <= 1'b0;
			vld_s2        <= 1'b0;
			vld_s3        <= 1'b0;
			m_tvalid      <= 1'b0;
		end else begin
			state_q   <= state_d;
			load_a_s1 <= (state_q == ST_FETCH);
			issue_s1  <= issue_vld;
			vld_s2    <= issue_s1;
			vld_s3    <= vld_s2;
			if (cfg_we) begin
				agent_count_q <= cfg_wdata;
			end
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			a_q      <= a_full[AW-1:0];
			b_q      <= b_full[AW-1:0];
			ax_q     <= in_row[0];
			bx_q     <= in_col[0];
			diag_q   <= (in_row[IDX_W-1:1] == in_col[IDX_W-1:1]);
			acc_q    <= '0;
			status_q <= ((in_op == OP_WRITE) ? slot_bad : idx_bad) ? STS_RANGE : STS_OK;
		end else if (vld_s3) begin
			if (diag_q) begin
				acc_q <= acc_q + ENTRY_W'(prod_s3);
			end else begin
				acc_q <= acc_q - ENTRY_W'(prod_s3);
			end
		end
		if (state_q == ST_FETCH) begin
			k_q <= diag_q ? '0 : b_q;
		end else if (state_q == ST_ISSUE) begin
			k_q <= k_q + AW'(1);
		end
		if (load_a_s1) begin
			pa_q <= ram_rdata;
		end
		d0_s2   <= DIFF_W'(pa_c0) - DIFF_W'(pk_c0);
		d1_s2   <= DIFF_W'(pa_c1) - DIFF_W'(pk_c1);
		prod_s3 <= d0_s2 * d1_s2;
		if (out_load) begin
			m_tdata <= acc_q;
			m_tuser <= status_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (!issue_s1 && !vld_s2 && !vld_s3))
		else $error("result taken with products still in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && in_op == OP_READ && idx_bad) |=> (state_q == ST_DONE))
		else $error("out-of-range read entered accumulation");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("error status with nonzero entry");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |-> (NW'(k_q) < n_cnt))
		else $error("agent index beyond agents in use");

endmodule

`default_nettype wire

// ===== test/localization_fisher_matrix_entry_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// localization_fisher_matrix_entry_tb
// Self-checking regression of the Fisher matrix entry block. Agent positions
// are written, then single matrix entries are read under several agent
// counts, including counts that leave no variable agents and counts above
// the store size. A local predictor tracks positions and the agent count and
// computes every entry and status. The stream sides idle and stall at random,
// with one long output stall and, in each phase, one pause until all results have drained.
// ----------------------------------------------------------------------------
module localization_fisher_matrix_entry_tb;

	import lfme_pkg::*;

	localparam int MAX_AGENTS   = 16;
	localparam int ANCHOR_COUNT = 3;
	localparam int QUIET_LIMIT  = 4000;
	localparam int LONG_HOLD    = 400;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct {
		opcode_t                   op;
		logic [SLOT_W-1:0]         slot;
		logic signed [POS_W-1:0]   pos_x;
		logic signed [POS_W-1:0]   pos_y;
		logic [IDX_W-1:0]          row;
		logic [IDX_W-1:0]          col;
		bit                        drain_first;
	} fisher_req_t;

	typedef struct {
		logic signed [ENTRY_W-1:0] value;
		status_t                   status;
	} fisher_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [IN_TDATA_W-1:0]   s_tdata = '0;
	logic                    s_tuser = 1'b0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_tdata;
	logic                    m_tuser;
	logic                    cfg_we = 1'b0;
	logic [CNT_W-1:0]        cfg_wdata = '0;

	fisher_req_t             request_queue[$];
	fisher_result_t          entry_queue[$];
	fisher_req_t             cur_req;
	logic signed [POS_W-1:0] slot_x [MAX_AGENTS];
	logic signed [POS_W-1:0] slot_y [MAX_AGENTS];
	logic [CNT_W-1:0]        agent_count_cfg = 5'd4;
	idle_mode_t              phase_mode = IDLE_NONE;
	bit                      long_hold_req = 1'b0;
	int                      mismatches = 0;

	localization_fisher_matrix_entry #(
		.MAX_AGENTS  (MAX_AGENTS),
		.ANCHOR_COUNT(ANCHOR_COUNT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint axis_delta(int unsigned a, int unsigned k, bit axis);
		if (axis)
			return longint'(slot_y[a]) - longint'(slot_y[k]);
		return longint'(slot_x[a]) - longint'(slot_x[k]);
	endfunction

	function automatic fisher_result_t fisher_entry_of(fisher_req_t req);
		fisher_result_t res;
		int unsigned    n;
		int unsigned    vars;
		int unsigned    a;
		int unsigned    b;
		res.value  = '0;
		res.status = STS_OK;
		if (req.op == OP_WRITE) begin
			slot_x[req.slot] = req.pos_x;
			slot_y[req.slot] = req.pos_y;
		end else begin
			n    = (agent_count_cfg > MAX_AGENTS) ? MAX_AGENTS : agent_count_cfg;
			vars = (n > ANCHOR_COUNT) ? n - ANCHOR_COUNT : 0;
			if (req.row >= 2 * vars || req.col >= 2 * vars) begin
				res.status = STS_RANGE;
			end else begin
				a = req.row[4:1] + ANCHOR_COUNT;
				b = req.col[4:1] + ANCHOR_COUNT;
				if (a == b) begin
					for (int unsigned k = 0; k < n; k++)
						if (k != a)
							res.value = res.value +
								axis_delta(a, k, req.row[0]) * axis_delta(a, k, req.col[0]);
				end else begin
					res.value = -(axis_delta(a, b, req.row[0]) * axis_delta(a, b, req.col[0]));
				end
			end
		end
		return res;
	endfunction

	function automatic logic signed [POS_W-1:0] pick_extreme(int unsigned sel);
		case (sel % 4)
			0: return 24'sh800000;
			1: return 24'sh7fffff;
			2: return 24'sh000000;
			default: return 24'shffffff;
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (request_queue.size() != 0 || s_tvalid || entry_queue.size() != 0);
	endtask

	task automatic write_agent_count(logic [CNT_W-1:0] value);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		agent_count_cfg = value;
		@(negedge clk);
	endtask

	// driver: hold the transaction until accepted, then advance
	always @(posedge clk) begin : driver
		bit present;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				entry_queue = {entry_queue, fisher_entry_of(cur_req)};
			if (!s_tvalid || s_tready) begin
				present = request_queue.size() != 0;
				if ((phase_mode == IDLE_SENDER && $urandom_range(99) < 59) ||
				    (phase_mode == IDLE_BOTH && $urandom_range(99) < 23))
					present = 1'b0;
				if (present && request_queue[0].drain_first && entry_queue.size() != 0)
					present = 1'b0;
				if (present) begin
					cur_req = request_queue.pop_front();
					s_tdata <= {2'b00, cur_req.col, cur_req.row, cur_req.pos_y,
					            cur_req.pos_x, cur_req.slot};
					s_tuser <= cur_req.op;
				end
				s_tvalid <= present;
			end
		end
	end

	// receiver: random stalls plus one long hold-off
	always @(posedge clk) begin : receiver
		int hold_left;
		bit hold_done;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
			hold_done = 1'b0;
		end else if (long_hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if ((phase_mode == IDLE_RECEIVER && $urandom_range(99) < 59) ||
		             (phase_mode == IDLE_BOTH && $urandom_range(99) < 23)) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : monitor
		fisher_result_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (entry_queue.size() == 0) begin
				report_mismatch($sformatf("unexpected result value %h status %b",
				                          m_tdata, m_tuser));
			end else begin
				exp_res = entry_queue.pop_front();
				if (m_tdata !== exp_res.value)
					report_mismatch($sformatf("entry_value %h, expected %h",
					                          m_tdata, exp_res.value));
				if (m_tuser !== exp_res.status)
					report_mismatch($sformatf("status %b, expected %b",
					                          m_tuser, exp_res.status));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		int quiet;
		if (!arst_n) begin
			quiet = 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
				$display("localization_fisher_matrix_entry regression: fail");
				$finish;
			end
		end
	end

	initial begin : stimulus
		fisher_req_t      req;
		logic [CNT_W-1:0] phase_counts [11];
		int unsigned      n_items;
		int unsigned      n_use;
		int unsigned      span;
		phase_counts = '{5'd16, 5'd4, 5'd10, 5'd31, 5'd3, 5'd0, 5'd17, 5'd7, 5'd16, 5'd5, 5'd12};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fill every slot with extreme coordinates, then read at the reset count
		for (int i = 0; i < MAX_AGENTS; i++) begin
			req.op          = OP_WRITE;
			req.slot        = SLOT_W'(i);
			req.pos_x       = pick_extreme(i);
			req.pos_y       = pick_extreme(3 - (i % 4) + i / 4);
			req.row         = IDX_W'($urandom);
			req.col         = IDX_W'($urandom);
			req.drain_first = 1'b0;
			request_queue = {request_queue, req};
		end
		for (int i = 0; i < 7; i++) begin
			req.op    = OP_READ;
			req.slot  = SLOT_W'($urandom);
			req.pos_x = POS_W'($urandom);
			req.pos_y = POS_W'($urandom);
			case (i)
				0: begin req.row = 0;  req.col = 0;  end
				1: begin req.row = 1;  req.col = 1;  end
				2: begin req.row = 0;  req.col = 1;  end
				3: begin req.row = 1;  req.col = 0;  end
				4: begin req.row = 2;  req.col = 0;  end
				5: begin req.row = 0;  req.col = 2;  end
				default: begin req.row = 31; req.col = 31; end
			endcase
			req.drain_first = 1'b0;
			request_queue = {request_queue, req};
		end

		for (int p = 0; p < 11; p++) begin
			wait_drained();
			write_agent_count(phase_counts[p]);
			phase_mode    = idle_mode_t'(p % 4);
			long_hold_req = (p == 8);
			n_use   = (phase_counts[p] > MAX_AGENTS) ? MAX_AGENTS : phase_counts[p];
			span    = (n_use > ANCHOR_COUNT) ? 2 * (n_use - ANCHOR_COUNT) : 0;
			n_items = (span == 0) ? 20 : 42;
			for (int i = 0; i < n_items; i++) begin
				req.op    = ($urandom_range(99) < 35) ? OP_WRITE : OP_READ;
				req.slot  = SLOT_W'($urandom);
				req.pos_x = POS_W'($urandom);
				req.pos_y = POS_W'($urandom);
				if ($urandom_range(9) == 0) begin
					req.pos_x = pick_extreme($urandom);
					req.pos_y = pick_extreme($urandom);
				end else if ($urandom_range(9) == 0) begin
					req.pos_x = POS_W'($urandom_range(511) - 256);
					req.pos_y = POS_W'($urandom_range(511) - 256);
				end
				if (span == 0 || $urandom_range(9) == 0) begin
					req.row = IDX_W'($urandom);
					req.col = IDX_W'($urandom);
				end else begin
					req.row = IDX_W'($urandom_range(span - 1));
					if ($urandom_range(99) < 40)
						req.col = {req.row[4:1], 1'($urandom)};
					else
						req.col = IDX_W'($urandom_range(span - 1));
				end
				req.drain_first = (i == 10);
				request_queue = {request_queue, req};
			end
		end

		wait_drained();
		repeat (30) @(posedge clk);
		if (entry_queue.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", entry_queue.size()));
		if (mismatches == 0)
			$display("localization_fisher_matrix_entry regression: pass");
		else
			$display("localization_fisher_matrix_entry regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/lfme_pkg.sv
hdl/lfme_ram.sv
hdl/localization_fisher_matrix_entry.sv
test/localization_fisher_matrix_entry_tb.sv
